@@ rtl/direct_mapped_writeback_cache_assert.svh @@
// assertion macros for the direct-mapped write-back cache
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define DMWC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DMWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DMWC_ASSERT_IMPL(lbl, ante, cons, msg)
`define DMWC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/dmwc_pkg.sv @@
// types, constants and helper functions for the direct-mapped write-back cache
package dmwc_pkg;

  localparam int MAX_INDEX_BITS = 8;
  localparam int DEPTH          = 1 << MAX_INDEX_BITS;
  localparam int IDX_W          = MAX_INDEX_BITS;
  localparam int ADDR_W         = 32;
  localparam int DATA_W         = 32;
  localparam int TAG_W          = ADDR_W - 1;
  localparam int CFG_W          = 4;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic [CFG_W-1:0] CFG_RESET     = CFG_W'(8);
  localparam logic [CFG_W-1:0] CB_ONE        = CFG_W'(1);
  localparam logic [CFG_W-1:0] CB_MAX        = CFG_W'(MAX_INDEX_BITS);
  localparam logic             REG_INDEX_BITS = 1'b0;
  localparam logic             OP_LOOKUP     = 1'b0;
  localparam logic             OP_INSERT     = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic              mark_dirty;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_data;
    logic              conflict;
    logic              evict_valid;
    logic [ADDR_W-1:0] evict_address;
    logic [DATA_W-1:0] evict_data;
  } rsp_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              dirty;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } wr_t;

  // clamp the index width register into 1..MAX_INDEX_BITS
  function automatic logic [CFG_W-1:0] eff_bits(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v < CB_ONE) r = CB_ONE;
    if (v > CB_MAX) r = CB_MAX;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] index_of(input logic [ADDR_W-1:0] addr,
                                                input logic [CFG_W-1:0]  cb);
    logic [IDX_W-1:0] mask;
    mask = ~({IDX_W{1'b1}} << cb);
    return addr[IDX_W-1:0] & mask;
  endfunction

  function automatic logic [ADDR_W-1:0] stored_addr(input logic [TAG_W-1:0] tag,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic [CFG_W-1:0] cb);
    logic [ADDR_W-1:0] t;
    t = {1'b0, tag} >> (cb - CB_ONE);
    return (t << cb) | ADDR_W'(idx);
  endfunction

endpackage

@@ rtl/dmwc_cfg.sv @@
// apb register block holding the index width
module dmwc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dmwc_pkg::PADDR_W-1:0] paddr,
  input  logic [dmwc_pkg::PDATA_W-1:0] pwdata,
  output logic [dmwc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [dmwc_pkg::CFG_W-1:0]  index_bits
);

  logic [dmwc_pkg::CFG_W-1:0] index_bits_r;
  logic                       sel_index;
  logic                       wr_en;

  assign pready    = 1'b1;
  assign sel_index = (paddr[2] == dmwc_pkg::REG_INDEX_BITS);
  assign wr_en     = psel && penable && pwrite && pready && sel_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_bits_r <= dmwc_pkg::CFG_RESET;
    end else if (wr_en) begin
      index_bits_r <= pwdata[dmwc_pkg::CFG_W-1:0];
    end
  end

  assign prdata     = sel_index ? dmwc_pkg::PDATA_W'(index_bits_r) : '0;
  assign index_bits = index_bits_r;

endmodule

@@ rtl/dmwc_store.sv @@
// entry memory with valid bits, registered read and write forwarding
module dmwc_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [dmwc_pkg::IDX_W-1:0] rd_idx,
  input  dmwc_pkg::wr_t             wr,
  output dmwc_pkg::entry_t          entry
);

  `include "direct_mapped_writeback_cache_assert.svh"

  dmwc_pkg::entry_t           mem [dmwc_pkg::DEPTH];
  logic [dmwc_pkg::DEPTH-1:0] valid_r;
  dmwc_pkg::entry_t           rd_r;
  logic                       vld_r;
  logic                       byp_r;
  dmwc_pkg::entry_t           byp_entry_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.entry;
    end
    rd_r        <= mem[rd_idx];
    byp_entry_r <= wr.entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_r   <= 1'b0;
      byp_r   <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.idx] <= 1'b1;
      end
      vld_r <= valid_r[rd_idx];
      byp_r <= wr.en && (wr.idx == rd_idx);
    end
  end

  // never-written entries read as all zero
  always_comb begin
    if (byp_r) begin
      entry = byp_entry_r;
    end else if (vld_r) begin
      entry = rd_r;
    end else begin
      entry = '0;
    end
  end

  `DMWC_ASSERT_NEXT(a_forward, wr.en && (wr.idx == rd_idx), entry == $past(wr.entry), "write not forwarded to following read")

endmodule

@@ rtl/dmwc_core.sv @@
// hit check, entry update and result register
module dmwc_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  dmwc_pkg::req_t              req,
  input  logic [dmwc_pkg::IDX_W-1:0]  idx,
  input  logic [dmwc_pkg::CFG_W-1:0]  cb,
  input  dmwc_pkg::entry_t            entry,
  output dmwc_pkg::wr_t               wr,
  output logic                        rsp_strobe,
  output dmwc_pkg::rsp_t              rsp
);

  `include "direct_mapped_writeback_cache_assert.svh"

  logic                       s1_vld_r;
  dmwc_pkg::req_t             s1_req_r;
  logic [dmwc_pkg::IDX_W-1:0] s1_idx_r;
  logic                       out_strobe_r;
  dmwc_pkg::rsp_t             out_rsp_r;

  logic [dmwc_pkg::ADDR_W-1:0] stored;
  logic                        same;
  logic                        nonzero;
  logic                        do_wr;
  logic                        evict;
  dmwc_pkg::rsp_t              rsp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_vld_r     <= accept;
      out_strobe_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r <= req;
      s1_idx_r <= idx;
    end
    out_rsp_r <= rsp_nxt;
  end

  always_comb begin
    stored  = dmwc_pkg::stored_addr(entry.tag, s1_idx_r, cb);
    same    = (stored == s1_req_r.address);
    nonzero = (|entry.tag) || entry.dirty || (|entry.data);
    do_wr   = (s1_req_r.operation == dmwc_pkg::OP_INSERT) &&
              !(same && (entry.data == s1_req_r.write_data));
    evict   = do_wr && !same && entry.dirty;

    rsp_nxt.hit           = same;
    rsp_nxt.read_data     = same ? entry.data : '0;
    rsp_nxt.conflict      = nonzero && !same;
    rsp_nxt.evict_valid   = evict;
    rsp_nxt.evict_address = evict ? stored : '0;
    rsp_nxt.evict_data    = evict ? entry.data : '0;

    wr.en          = s1_vld_r && do_wr;
    wr.idx         = s1_idx_r;
    wr.entry.tag   = s1_req_r.address[dmwc_pkg::ADDR_W-1:1];
    wr.entry.dirty = same ? 1'b1 : s1_req_r.mark_dirty;
    wr.entry.data  = s1_req_r.write_data;
  end

  assign rsp_strobe = out_strobe_r;
  assign rsp        = out_rsp_r;

  `DMWC_ASSERT_NEXT(a_latency, accept, s1_vld_r && out_strobe_r == $past(s1_vld_r), "request did not reach stage one")
  `DMWC_ASSERT_IMPL(a_evict_miss, out_strobe_r && out_rsp_r.evict_valid, !out_rsp_r.hit && out_rsp_r.conflict, "eviction on a hit")
  `DMWC_ASSERT_IMPL(a_hit_clean, out_strobe_r && out_rsp_r.hit, !out_rsp_r.conflict && !out_rsp_r.evict_valid, "hit with conflict or eviction")
  `DMWC_ASSERT_IMPL(a_miss_data, out_strobe_r && !out_rsp_r.hit, out_rsp_r.read_data == '0, "miss returned data")

endmodule

@@ rtl/direct_mapped_writeback_cache.sv @@
// top level of the direct-mapped write-back cache
// Direct-mapped write-back cache of 32-bit operands, up to 256 entries.
// Requests: raise start with in_req (lookup or insert); a request is taken
// at each rising edge where start is high and busy is low. busy stays low,
// so a new request can be taken in every cycle.
// Results: out_strobe marks out_rsp for one cycle. The entry is read into a
// register at the accepting edge together with the request; the hit check
// runs in the next cycle and loads the result register, which drives out_rsp.
// Results come back in request order.
// Throughput is one request per cycle; a request that rewrites an entry read
// by the next request is forwarded from the write port to that read.
// Configuration: APB register at byte address 0 holds index_bits; write it
// only while no request is in flight.
// Reset (rst_n low, synchronous) clears the per-entry valid bits, so every
// entry reads as tag 0, operand 0, clean; no clearing pass.
// The receiver cannot stall: each result must be taken in its strobe cycle.
module direct_mapped_writeback_cache (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  dmwc_pkg::req_t               in_req,
  output logic                         out_strobe,
  output dmwc_pkg::rsp_t               out_rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dmwc_pkg::PADDR_W-1:0] paddr,
  input  logic [dmwc_pkg::PDATA_W-1:0] pwdata,
  output logic [dmwc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  logic [dmwc_pkg::CFG_W-1:0] index_bits;
  logic [dmwc_pkg::CFG_W-1:0] cb;
  logic [dmwc_pkg::IDX_W-1:0] idx;
  logic                       accept;
  dmwc_pkg::wr_t              wr;
  dmwc_pkg::entry_t           entry;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cb     = dmwc_pkg::eff_bits(index_bits);
  assign idx    = dmwc_pkg::index_of(in_req.address, cb);

  dmwc_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .index_bits (index_bits)
  );

  dmwc_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (idx),
    .wr     (wr),
    .entry  (entry)
  );

  dmwc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req        (in_req),
    .idx        (idx),
    .cb         (cb),
    .entry      (entry),
    .wr         (wr),
    .rsp_strobe (out_strobe),
    .rsp        (out_rsp)
  );

endmodule

@@ bench/direct_mapped_writeback_cache_tb.sv @@
// testbench for the direct-mapped write-back cache: directed table, then random requests
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_tb;
  import dmwc_pkg::*;

  localparam logic [PADDR_W-1:0] INDEX_BITS_ADDR = PADDR_W'(4 * int'(REG_INDEX_BITS));
  localparam int NUM_DIRECTED    = 21;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int DRAIN_LIMIT     = 1000;
  localparam rsp_t NO_RSP        = '0;
  localparam logic [CFG_W-1:0] PHASE_BITS [NUM_PHASES] =
    '{4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd9, 4'd2, 4'd5};

  typedef struct packed {
    req_t req;
    logic typed;
    rsp_t want;
  } directed_t;

  logic                clk;
  logic                rst_n   = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  req_t                in_req  = '0;
  logic                out_strobe;
  rsp_t                out_rsp;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic [TAG_W-1:0]    tag_mem   [DEPTH];
  logic                dirty_mem [DEPTH];
  logic [DATA_W-1:0]   data_mem  [DEPTH];
  logic [CFG_W-1:0]    index_bits_q;

  rsp_t                pending_results [$];
  logic [ADDR_W-1:0]   recent_addrs [$];
  int                  mismatches = 0;

  // op, address, write data, mark dirty, typed, then hit, read data, conflict, evict fields
  directed_t directed_tab [NUM_DIRECTED] = '{
    {OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0, 1'b0, 1'b0, 64'h0},
    {OP_LOOKUP, 32'h0000_00A5, 32'hDEAD_BEEF, 1'b1, 1'b1, 1'b1, 32'h0, 1'b0, 1'b0, 64'h0},
    {OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, NO_RSP},
    {OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'h0, 1'b0, 1'b0, 64'h0},
    {OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, NO_RSP},
    {OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1,
     1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 64'h0},
    {OP_INSERT, 32'h0000_00FF, 32'h0000_1234, 1'b0, 1'b1,
     1'b0, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    {OP_INSERT, 32'h0000_00FF, 32'h0000_1234, 1'b1, 1'b0, NO_RSP},
    {OP_INSERT, 32'h0000_01FF, 32'h0000_0000, 1'b0, 1'b0, NO_RSP},
    {OP_INSERT, 32'h0000_01FF, 32'h0000_5678, 1'b0, 1'b0, NO_RSP},
    {OP_INSERT, 32'h0000_00FF, 32'h0000_0009, 1'b0, 1'b0, NO_RSP},
    {OP_INSERT, 32'h8000_0010, 32'h8000_0001, 1'b1, 1'b0, NO_RSP},
    {OP_LOOKUP, 32'h8000_0010, 32'h0000_0000, 1'b0, 1'b0, NO_RSP},
    {OP_INSERT, 32'h0000_0010, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_RSP},
    {OP_INSERT, 32'h0000_0010, 32'h7FFF_FFFE, 1'b0, 1'b0, NO_RSP},
    {OP_LOOKUP, 32'h0000_0110, 32'h0000_0000, 1'b1, 1'b0, NO_RSP},
    {OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, NO_RSP},
    {OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, NO_RSP},
    {OP_LOOKUP, 32'h5555_5555, 32'h0000_0000, 1'b0, 1'b0, NO_RSP},
    {OP_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, 1'b0, NO_RSP},
    {OP_INSERT, 32'h1234_5655, 32'h0000_0000, 1'b0, 1'b0, NO_RSP}
  };

  direct_mapped_writeback_cache DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("direct_mapped_writeback_cache_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_val);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want_val);
    mismatches++;
  endtask

  function automatic int unsigned active_bits();
    if (index_bits_q < CB_ONE) return 1;
    if (index_bits_q > CB_MAX) return MAX_INDEX_BITS;
    return int'(index_bits_q);
  endfunction

  // one cache access against the local copy of the entries
  function automatic rsp_t cache_access(input req_t r);
    rsp_t              rsp;
    int unsigned       cb;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] held_addr;
    logic              same;
    cb = active_bits();
    idx = IDX_W'(r.address & ((32'h1 << cb) - 32'h1));
    held_addr = (({1'b0, tag_mem[idx]} >> (cb - 1)) << cb) | ADDR_W'(idx);
    same = (held_addr == r.address);
    rsp = '0;
    rsp.hit = same;
    rsp.read_data = same ? data_mem[idx] : '0;
    rsp.conflict = !same && (tag_mem[idx] != '0 || dirty_mem[idx] || data_mem[idx] != '0);
    if (r.operation == OP_INSERT && !(same && data_mem[idx] == r.write_data)) begin
      if (!same && dirty_mem[idx]) begin
        rsp.evict_valid = 1'b1;
        rsp.evict_address = held_addr;
        rsp.evict_data = data_mem[idx];
      end
      dirty_mem[idx] = same ? 1'b1 : r.mark_dirty;
      tag_mem[idx] = r.address[ADDR_W-1:1];
      data_mem[idx] = r.write_data;
    end
    return rsp;
  endfunction

  // mostly reused or index-colliding addresses so entries get hit, rewritten and evicted
  function automatic req_t random_request();
    req_t              r;
    int unsigned       cb;
    logic [ADDR_W-1:0] mask;
    logic [IDX_W-1:0]  idx;
    int                pick;
    cb = active_bits();
    mask = (32'h1 << cb) - 32'h1;
    r.operation = ($urandom_range(0, 99) < 60) ? OP_INSERT : OP_LOOKUP;
    pick = $urandom_range(0, 99);
    if (recent_addrs.size() != 0 && pick < 40)
      r.address = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
    else if (recent_addrs.size() != 0 && pick < 65)
      r.address = ($urandom() & ~mask) |
                  (recent_addrs[$urandom_range(0, recent_addrs.size() - 1)] & mask);
    else if (pick < 75)
      r.address = $urandom_range(0, 511);
    else
      r.address = $urandom();
    idx = IDX_W'(r.address & mask);
    pick = $urandom_range(0, 99);
    if (pick < 30)
      r.write_data = data_mem[idx];
    else if (pick < 38)
      r.write_data = '0;
    else if (pick < 42)
      r.write_data = '1;
    else
      r.write_data = $urandom();
    r.mark_dirty = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_request(input req_t r, input logic typed, input rsp_t want);
    rsp_t predicted;
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    predicted = cache_access(r);
    pending_results.push_back(typed ? want : predicted);
    if (r.operation == OP_INSERT) begin
      recent_addrs.push_back(r.address);
      if (recent_addrs.size() > 16) void'(recent_addrs.pop_front());
    end
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (3) @(posedge clk);
  endtask

  // write index_bits, then read it back
  task automatic write_index_bits(input logic [CFG_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= INDEX_BITS_ADDR;
    pwdata <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    index_bits_q = v;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CFG_W-1:0] != v) report_mismatch("index_bits readback", prdata, 32'(v));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected", 32'(out_rsp.hit), 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.hit != want.hit)
          report_mismatch("hit", 32'(out_rsp.hit), 32'(want.hit));
        if (out_rsp.read_data != want.read_data)
          report_mismatch("read_data", out_rsp.read_data, want.read_data);
        if (out_rsp.conflict != want.conflict)
          report_mismatch("conflict", 32'(out_rsp.conflict), 32'(want.conflict));
        if (out_rsp.evict_valid != want.evict_valid)
          report_mismatch("evict_valid", 32'(out_rsp.evict_valid), 32'(want.evict_valid));
        if (out_rsp.evict_address != want.evict_address)
          report_mismatch("evict_address", out_rsp.evict_address, want.evict_address);
        if (out_rsp.evict_data != want.evict_data)
          report_mismatch("evict_data", out_rsp.evict_data, want.evict_data);
      end
    end
  end

  initial begin
    int pct;
    for (int i = 0; i < DEPTH; i++) begin
      tag_mem[i] = '0;
      dirty_mem[i] = 1'b0;
      data_mem[i] = '0;
    end
    index_bits_q = CFG_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_request(directed_tab[i].req, directed_tab[i].typed, directed_tab[i].want);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_index_bits(PHASE_BITS[p]);
      pct = (p < 3) ? 15 : (p < 6) ? 46 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ((i / 16) % 3 != 2) sender_gap(pct);
        send_request(random_request(), 1'b0, NO_RSP);
        if ($urandom_range(0, 63) == 0) drain();
      end
      drain();
    end

    if (pending_results.size() != 0)
      report_mismatch("results never arrived", pending_results.size(), 32'h0);
    if (mismatches == 0) begin
      $display("direct_mapped_writeback_cache_tb: PASS");
    end else begin
      $display("direct_mapped_writeback_cache_tb: FAIL");
    end
    $finish;
  end

endmodule
